### rtl/core/sorted_priority_queue_unit_macros.svh
// Assertion macros for the sorted priority queue unit.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue_unit: same-cycle check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue_unit: next-cycle check failed");

`else

`define SPQ_ASSERT_IMPL(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY    = 64;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;

    // Result word layout, lowest bit up.
    localparam int OUT_MIN_LSB    = 0;
    localparam int OUT_EMPTY_BIT  = OUT_MIN_LSB + VALUE_W;
    localparam int OUT_COUNT_LSB  = OUT_EMPTY_BIT + 1;
    localparam int OUT_STATUS_LSB = OUT_COUNT_LSB + COUNT_OUT_W;
    localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int IN_TDATA_W     = VALUE_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_LAST,
        ST_DEL_SCAN,
        ST_FINISH
    } state_t;

    // Controller -> datapath.
    typedef struct packed {
        logic load;      // latch request, start operation
        logic ins_step;  // one downward shift step of an insert
        logic ins_last;  // write the value at entry 0
        logic del_step;  // one upward search/shift step of a delete
        logic finish;    // load the output register
    } ctrl_cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic in_delete; // pending request is a delete
        logic full;
        logic empty;
        logic ins_ge;    // entry under scan is not smaller than the value
        logic idx_zero;  // scan reached entry 0
        logic del_last;  // scan is on the last stored entry
        logic out_free;  // output register can take a result
    } dp_status_t;

endpackage

### rtl/core/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Group                       Contents
// request   in   s_tvalid/s_tready/s_tdata   tdata: value; tuser: command
// result    out  m_tvalid/m_tready/m_tdata   tdata: min, empty, count, status
//
// One request at a time, one result per request. Inserts scan down from the last
// entry to the sorted position, deletes scan every entry upward, and a full insert
// or empty delete skips the scan. The store RAM reads and writes one entry per cycle.
// Reset clears the entry count; the store needs no clearing pass.
// A held result does not block the next request; that request's finish waits
// in FINISH until the output register frees.

`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // request
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
    input  logic                            s_tuser,  // [0] command: 0 insert, 1 delete
    // result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata   // [31:0] min_value, [32] is_empty,
                                                      // [39:33] entry_count,
                                                      // [41:40] status, [47:42] zero
);

    spq_pkg::ctrl_cmd_t  cmd;
    spq_pkg::dp_status_t status;

    // FSM: idle -> scan (insert downward / delete upward) -> finish
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store RAM, count/min tracking and the output register
    spq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    // An accepted request always leaves idle.
    `SPQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // An empty store reports a zero minimum.
    `SPQ_ASSERT_IMPL(a_empty_min_zero, m_tvalid && m_tdata[spq_pkg::OUT_EMPTY_BIT],
        m_tdata[spq_pkg::OUT_MIN_LSB +: spq_pkg::VALUE_W] == '0)
    // Status is always one of the defined codes.
    `SPQ_ASSERT_IMPL(a_status_code, m_tvalid,
        m_tdata[spq_pkg::OUT_STATUS_LSB +: spq_pkg::STATUS_W] <= spq_pkg::STATUS_ABSENT)
    // Scan and output steps are never commanded together.
    `SPQ_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule

### rtl/core/spq_ram.sv
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  spq_pkg::dp_status_t status,
    output spq_pkg::ctrl_cmd_t  cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.in_delete)
                    begin
                        state_next = status.empty ? spq_pkg::ST_FINISH : spq_pkg::ST_DEL_SCAN;
                    end
                    else if (status.full)
                    begin
                        state_next = spq_pkg::ST_FINISH;
                    end
                    else if (status.empty)
                    begin
                        state_next = spq_pkg::ST_INS_LAST;
                    end
                    else
                    begin
                        state_next = spq_pkg::ST_INS_SCAN;
                    end
                end
            end
            spq_pkg::ST_INS_SCAN:
            begin
                if (!status.ins_ge)
                begin
                    state_next = spq_pkg::ST_FINISH;
                end
                else if (status.idx_zero)
                begin
                    state_next = spq_pkg::ST_INS_LAST;
                end
            end
            spq_pkg::ST_INS_LAST:
            begin
                state_next = spq_pkg::ST_FINISH;
            end
            spq_pkg::ST_DEL_SCAN:
            begin
                if (status.del_last)
                begin
                    state_next = spq_pkg::ST_FINISH;
                end
            end
            spq_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            spq_pkg::ST_INS_SCAN:
            begin
                cmd.ins_step = 1'b1;
            end
            spq_pkg::ST_INS_LAST:
            begin
                cmd.ins_last = 1'b1;
            end
            spq_pkg::ST_DEL_SCAN:
            begin
                cmd.del_step = 1'b1;
            end
            spq_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [spq_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  spq_pkg::ctrl_cmd_t                 cmd,
    output spq_pkg::dp_status_t                status
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] min_reg;
    logic signed [spq_pkg::VALUE_W-1:0] min_next;
    logic [spq_pkg::CNT_W-1:0]          count_reg;
    logic [spq_pkg::CNT_W-1:0]          count_next;
    logic [spq_pkg::IDX_W-1:0]          idx_reg;
    logic                               found_reg;
    logic                               found_next;
    spq_pkg::status_t                   status_reg;
    spq_pkg::status_t                   status_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [spq_pkg::OUT_TDATA_W-1:0]    out_data_reg;
    logic [spq_pkg::OUT_TDATA_W-1:0]    out_data_next;

    logic                               ram_we;
    logic [spq_pkg::IDX_W-1:0]          ram_waddr;
    logic [spq_pkg::VALUE_W-1:0]        ram_wdata;
    logic [spq_pkg::IDX_W-1:0]          rd_addr;
    logic [spq_pkg::VALUE_W-1:0]        rd_data;

    logic                               full;
    logic                               empty;
    logic                               ins_ge;
    logic                               match;
    logic                               del_last;

    spq_ram #(
        .WIDTH (spq_pkg::VALUE_W),
        .DEPTH (spq_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign full     = (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign empty    = (count_reg == '0);
    assign ins_ge   = ($signed(rd_data) >= value_reg);
    assign match    = (rd_data == value_reg);
    assign del_last = ((spq_pkg::CNT_W'(idx_reg) + spq_pkg::CNT_W'(1)) == count_reg);

    always_comb
    begin
        status.in_delete = (s_tuser == spq_pkg::CMD_DELETE);
        status.full      = full;
        status.empty     = empty;
        status.ins_ge    = ins_ge;
        status.idx_zero  = (idx_reg == '0);
        status.del_last  = del_last;
        status.out_free  = !out_valid_reg || m_tready;
    end

    // Store read address: scan start on load, then one entry per step.
    always_comb
    begin
        rd_addr = idx_reg;
        if (cmd.load)
        begin
            rd_addr = (s_tuser == spq_pkg::CMD_DELETE) ? '0
                                                       : spq_pkg::IDX_W'(count_reg - 1'b1);
        end
        else if (cmd.ins_step)
        begin
            rd_addr = idx_reg - 1'b1;
        end
        else if (cmd.del_step)
        begin
            rd_addr = idx_reg + 1'b1;
        end
    end

    // Store write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = rd_data;
        if (cmd.ins_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg + 1'b1;
            ram_wdata = ins_ge ? rd_data : value_reg;
        end
        else if (cmd.ins_last)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = value_reg;
        end
        else if (cmd.del_step)
        begin
            ram_we    = found_reg;
            ram_waddr = idx_reg - 1'b1;
            ram_wdata = rd_data;
        end
    end

    // Count, minimum, status
    always_comb
    begin
        count_next  = count_reg;
        min_next    = min_reg;
        found_next  = found_reg;
        status_next = status_reg;
        if (cmd.load)
        begin
            found_next  = 1'b0;
            status_next = spq_pkg::STATUS_DONE;
            if (s_tuser == spq_pkg::CMD_DELETE)
            begin
                if (empty)
                begin
                    status_next = spq_pkg::STATUS_ABSENT;
                end
            end
            else if (full)
            begin
                status_next = spq_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (empty || ($signed(s_tdata) <= min_reg))
                begin
                    min_next = $signed(s_tdata);
                end
            end
        end
        else if (cmd.del_step)
        begin
            if (!found_reg && match)
            begin
                found_next = 1'b1;
            end
            // entry 1 moving down to entry 0 is the new minimum
            if (found_reg && (idx_reg == spq_pkg::IDX_W'(1)))
            begin
                min_next = $signed(rd_data);
            end
            if (del_last)
            begin
                if (found_reg || match)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = spq_pkg::STATUS_ABSENT;
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[spq_pkg::OUT_MIN_LSB +: spq_pkg::VALUE_W] =
                empty ? '0 : min_reg;
            out_data_next[spq_pkg::OUT_EMPTY_BIT] = empty;
            out_data_next[spq_pkg::OUT_COUNT_LSB +: spq_pkg::COUNT_OUT_W] =
                spq_pkg::COUNT_OUT_W'(count_reg);
            out_data_next[spq_pkg::OUT_STATUS_LSB +: spq_pkg::STATUS_W] = status_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            found_reg     <= 1'b0;
            status_reg    <= spq_pkg::STATUS_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg      <= min_next;
        out_data_reg <= out_data_next;
        idx_reg      <= rd_addr;
        if (cmd.load)
        begin
            value_reg <= $signed(s_tdata);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### bench/spq_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the sorted store and checks every result.
module spq_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
    input  logic                            s_tuser,  // [0] command
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] min, [32] empty,
                                                      // [39:33] count, [41:40] status
    output int                              mismatch_count,
    output int                              outstanding
);
    import spq_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  min_value;
        logic                       is_empty;
        logic [COUNT_OUT_W-1:0]     entry_count;
        logic [STATUS_W-1:0]        status;
    } queue_report_t;

    logic signed [VALUE_W-1:0] sorted_shadow[$];
    queue_report_t             pending_reports[$];
    queue_report_t             oldest;

    // Applies one request to the shadow store and returns the report it should produce.
    function automatic queue_report_t apply_request(input logic cmd,
                                                    input logic signed [VALUE_W-1:0] value);
        queue_report_t       rpt;
        int                  pos;
        logic [STATUS_W-1:0] st;
        pos = 0;
        st  = STATUS_DONE;
        if (cmd == CMD_INSERT) begin
            if (sorted_shadow.size() >= CAPACITY) begin
                st = STATUS_FULL;
            end
            else begin
                // lands ahead of the first entry not smaller, so duplicates stack up
                while (pos < sorted_shadow.size() && sorted_shadow[pos] < value)
                    pos++;
                sorted_shadow.insert(pos, value);
            end
        end
        else begin
            while (pos < sorted_shadow.size() && sorted_shadow[pos] != value)
                pos++;
            if (pos >= sorted_shadow.size())
                st = STATUS_ABSENT;
            else
                sorted_shadow.delete(pos);
        end
        rpt.min_value   = (sorted_shadow.size() > 0) ? sorted_shadow[0] : '0;
        rpt.is_empty    = (sorted_shadow.size() == 0);
        rpt.entry_count = COUNT_OUT_W'(sorted_shadow.size());
        rpt.status      = st;
        return rpt;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatch_count < 10)
            $display("checker: %s mismatch, expected %h, got %h", field, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sorted_shadow.delete();
            pending_reports.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else begin
            // result side first: a result can never belong to a request taken this edge
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("checker: result with no request pending, m_tdata %h",
                                 m_tdata);
                    mismatch_count++;
                end
                else begin
                    oldest = pending_reports.pop_front();
                    if (m_tdata[OUT_MIN_LSB +: VALUE_W] !== oldest.min_value)
                        note_mismatch("min_value", oldest.min_value,
                                      m_tdata[OUT_MIN_LSB +: VALUE_W]);
                    if (m_tdata[OUT_EMPTY_BIT] !== oldest.is_empty)
                        note_mismatch("is_empty", 32'(oldest.is_empty),
                                      32'(m_tdata[OUT_EMPTY_BIT]));
                    if (m_tdata[OUT_COUNT_LSB +: COUNT_OUT_W] !== oldest.entry_count)
                        note_mismatch("entry_count", 32'(oldest.entry_count),
                                      32'(m_tdata[OUT_COUNT_LSB +: COUNT_OUT_W]));
                    if (m_tdata[OUT_STATUS_LSB +: STATUS_W] !== oldest.status)
                        note_mismatch("status", 32'(oldest.status),
                                      32'(m_tdata[OUT_STATUS_LSB +: STATUS_W]));
                end
            end
            if (s_tvalid && s_tready)
                pending_reports.push_back(apply_request(s_tuser, $signed(s_tdata[VALUE_W-1:0])));
            outstanding = pending_reports.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int ITEM_TARGET    = 900;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int LONG_HOLD      = 400;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int          mismatch_count;
    int          outstanding;
    int          items_sent = 0;
    int          burst_left = 0;
    logic [31:0] live_values[$];   // values inserted and not yet picked for removal
    logic [31:0] value_pool[8];    // small set reused to get duplicates and hits

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_priority_queue_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spq_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input cmd_t cmd, input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 4)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Insert with the given odds; otherwise mostly remove a live value, else a random one.
    task automatic random_request(input int insert_pct);
        logic [31:0] value;
        int          idx;
        if ($urandom_range(0, 99) < insert_pct) begin
            value = pick_value();
            live_values.push_back(value);
            send_request(CMD_INSERT, value);
        end
        else if (live_values.size() > 0 && $urandom_range(0, 9) != 0) begin
            idx   = $urandom_range(0, live_values.size() - 1);
            value = live_values[idx];
            live_values.delete(idx);
            send_request(CMD_DELETE, value);
        end
        else begin
            send_request(CMD_DELETE, $urandom);
        end
    endtask

    // Receiver: stall pattern in segments, plus two long hold-offs that back the block up.
    initial begin : receiver
        int mode;
        int seg_left;
        int results_taken;
        int next_hold_at;
        mode          = 0;
        seg_left      = 0;
        results_taken = 0;
        next_hold_at  = 150;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                results_taken++;
            @(negedge clk);
            if (results_taken >= next_hold_at) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                next_hold_at = (next_hold_at == 150) ? 600 : 32'h7fff_ffff;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (seg_left % 3 == 0);
            endcase
        end
    end

    // Watchdog: ends the run after too many cycles with no request or result moving.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        int phase_kind;
        int n;
        phase_no = 0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty store, extremes, duplicates, absent deletes, back to empty
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h7fff_ffff);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h0000_0001);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'haaaa_aaaa);
        send_request(CMD_INSERT, 32'h5555_5555);
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_DELETE, 32'h8000_0000);
        send_request(CMD_DELETE, 32'h0000_0005);
        send_request(CMD_DELETE, 32'h7fff_ffff);
        send_request(CMD_DELETE, 32'haaaa_aaaa);
        send_request(CMD_DELETE, 32'hffff_ffff);
        send_request(CMD_DELETE, 32'h5555_5555);
        send_request(CMD_DELETE, 32'h0000_0001);
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_DELETE, 32'h8000_0000);

        // random: fill past capacity, drain to empty, mixed traffic
        while (items_sent < ITEM_TARGET) begin
            if (phase_no < 2)
                phase_kind = phase_no;
            else
                phase_kind = ($urandom_range(0, 9) < 4) ? 0 :
                             ($urandom_range(0, 9) < 6) ? 1 : 2;
            phase_no++;
            case (phase_kind)
                0: begin
                    n = $urandom_range(70, 110);
                    repeat (n) random_request(90);
                end
                1: begin
                    n = 0;
                    while (live_values.size() > 0 && n < 120) begin
                        random_request(10);
                        n++;
                    end
                end
                default: begin
                    repeat (40) random_request(50);
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_unit.sv
bench/spq_result_checker.sv
bench/tb.sv
